// ===== rtl/core/pdtc_pkg.sv =====
`default_nettype none

package pdtc_pkg;

    localparam int unsigned PERIOD_W     = 11;
    localparam int unsigned ELAPSED_W    = 11;
    localparam int unsigned WORD_W       = 16;
    localparam int unsigned UPTIME_W     = 32;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_PERIOD = '0;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 11'd20;
    localparam logic [ELAPSED_W:0]   STEP_MS      = 12'd2000;

    localparam logic [WORD_W-1:0] TIME_RESET   = 16'h0000;
    localparam logic [WORD_W-1:0] DATE_RESET   = 16'h0021;

    localparam logic [WORD_W-1:0] MASK_KEEP_HI5 = 16'hFFE0;
    localparam logic [WORD_W-1:0] MINUTE_ONE    = 16'h0020;
    localparam logic [WORD_W-1:0] MASK_NO_MIN   = 16'hF81F;
    localparam logic [WORD_W-1:0] HOUR_ONE      = 16'h0800;
    localparam logic [WORD_W-1:0] MASK_HOUR     = 16'hF800;
    localparam logic [WORD_W-1:0] MASK_MINUTE   = 16'h07E0;
    localparam logic [WORD_W-1:0] MASK_LEAP     = 16'h0600;
    localparam logic [WORD_W-1:0] MONTH_DAY_ONE = 16'h0021;
    localparam logic [WORD_W-1:0] MASK_YEAR     = 16'hFE00;
    localparam logic [WORD_W-1:0] YEAR_JAN_ONE  = 16'h0221;
    localparam logic [WORD_W-1:0] MASK_MONTH    = 16'h01E0;

    localparam logic [WORD_W-1:0] MINUTE_WRAP = 16'(60 << 5);
    localparam logic [WORD_W-1:0] HOUR_WRAP   = 16'(24 << 11);
    localparam logic [WORD_W-1:0] MONTH_LAST  = 16'(12 << 5);

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_LOAD_TIME = 2'd1,
        REQ_LOAD_DATE = 2'd2
    } t_req_type;

    // Month 0 and months 13 to 15 are zero days long.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     days = 5'd30;
            4'd2:                                         days = 5'd28;
            default:                                      days = 5'd0;
        endcase
        return days;
    endfunction

    function automatic logic [WORD_W-1:0] bump_month(input logic [WORD_W-1:0] date);
        logic [WORD_W-1:0] b1;
        b1 = (date & MASK_KEEP_HI5) + MONTH_DAY_ONE;
        if ((b1 & MASK_MONTH) <= MONTH_LAST) begin
            return b1;
        end
        return (b1 & MASK_YEAR) + YEAR_JAN_ONE;
    endfunction

    function automatic logic [WORD_W-1:0] advance_date(input logic [WORD_W-1:0] date);
        logic [WORD_W-1:0] d1;
        logic [4:0]        day;
        logic [3:0]        month;
        d1    = date + 16'd1;
        day   = d1[4:0];
        month = d1[8:5];
        if (date[4:0] == 5'd31) begin
            return bump_month(date);
        end
        if (day <= 5'd28) begin
            return d1;
        end
        if (month == 4'd2 && (d1 & MASK_LEAP) == 16'd0) begin
            return (day <= 5'd29) ? d1 : bump_month(d1);
        end
        return (day <= month_days(month)) ? d1 : bump_month(d1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/packed_date_time_clock_unit.sv =====
`default_nettype none

// Wall clock in packed DOS time/date form with a wrapping millisecond uptime
// counter. Each beat is a tick (adds tick_period_ms, advancing the two-second
// field every 2000 ms with carries through minutes, hours and the date), a
// time word load or a date word load; request type 3 leaves the state alone.
// Every beat returns one result beat with the state after it. One beat is
// taken per clock unless the output stalls; a taken beat is held in the input
// register and its result is presented from the state/result register, with
// the whole update in between. tick_period_ms is at APB address 0 (reset 20).
module packed_date_time_clock_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,

    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_req_type,
    input  wire logic [pdtc_pkg::WORD_W-1:0]          i_load_value,

    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [pdtc_pkg::WORD_W-1:0]               o_time_word,
    output logic [pdtc_pkg::WORD_W-1:0]               o_date_word,
    output logic [pdtc_pkg::UPTIME_W-1:0]             o_uptime_ms,
    output logic                                      o_second_step,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pdtc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [pdtc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pdtc_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    logic [pdtc_pkg::PERIOD_W-1:0]   r_period;

    logic                            r_in_valid;
    pdtc_pkg::t_req_type             r_req;
    logic [pdtc_pkg::WORD_W-1:0]     r_load;

    logic                            r_out_valid;
    logic                            r_step;
    logic [pdtc_pkg::ELAPSED_W-1:0]  r_elapsed;
    logic [pdtc_pkg::WORD_W-1:0]     r_time;
    logic [pdtc_pkg::WORD_W-1:0]     r_date;
    logic [pdtc_pkg::UPTIME_W-1:0]   r_uptime;

    logic [pdtc_pkg::ELAPSED_W-1:0]  n_elapsed;
    logic [pdtc_pkg::WORD_W-1:0]     n_time;
    logic [pdtc_pkg::WORD_W-1:0]     n_date;
    logic [pdtc_pkg::UPTIME_W-1:0]   n_uptime;
    logic                            n_step;

    logic                            advance;
    logic                            cfg_write;
    logic                            period_sel;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign period_sel = (paddr == pdtc_pkg::ADDR_PERIOD);
    assign cfg_write  = psel && penable && pwrite && pready && period_sel;

    assign pready = 1'b1;
    assign prdata = period_sel
                  ? {{(pdtc_pkg::APB_DATA_W - pdtc_pkg::PERIOD_W){1'b0}}, r_period}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= pdtc_pkg::PERIOD_RESET;
        end else if (cfg_write) begin
            r_period <= pwdata[pdtc_pkg::PERIOD_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req  <= pdtc_pkg::t_req_type'(i_req_type);
            r_load <= i_load_value;
        end
    end

    // Next state for the beat held in the input register
    always_comb begin
        logic [pdtc_pkg::ELAPSED_W:0] sum;
        logic [pdtc_pkg::WORD_W-1:0]  t1;
        logic [pdtc_pkg::WORD_W-1:0]  t2;
        logic [pdtc_pkg::WORD_W-1:0]  t3;
        logic [pdtc_pkg::WORD_W-1:0]  t_adv;
        logic [pdtc_pkg::WORD_W-1:0]  d_adv;

        sum = {1'b0, r_elapsed} + {1'b0, r_period};
        t1  = r_time + 16'd1;
        t2  = (t1 & pdtc_pkg::MASK_KEEP_HI5) + pdtc_pkg::MINUTE_ONE;
        t3  = (t2 & pdtc_pkg::MASK_NO_MIN) + pdtc_pkg::HOUR_ONE;
        d_adv = r_date;
        if (t1[4:0] != 5'd30) begin
            t_adv = t1;
        end else if ((t2 & pdtc_pkg::MASK_MINUTE) != pdtc_pkg::MINUTE_WRAP) begin
            t_adv = t2;
        end else if ((t3 & pdtc_pkg::MASK_HOUR) != pdtc_pkg::HOUR_WRAP) begin
            t_adv = t3;
        end else begin
            t_adv = '0;
            d_adv = pdtc_pkg::advance_date(r_date);
        end

        n_elapsed = r_elapsed;
        n_time    = r_time;
        n_date    = r_date;
        n_uptime  = r_uptime;
        n_step    = 1'b0;
        case (r_req)
            pdtc_pkg::REQ_TICK: begin
                n_uptime = r_uptime + {{(pdtc_pkg::UPTIME_W - pdtc_pkg::PERIOD_W){1'b0}},
                                       r_period};
                if (sum >= pdtc_pkg::STEP_MS) begin
                    n_elapsed = pdtc_pkg::ELAPSED_W'(sum - pdtc_pkg::STEP_MS);
                    n_step    = 1'b1;
                    n_time    = t_adv;
                    n_date    = d_adv;
                end else begin
                    n_elapsed = sum[pdtc_pkg::ELAPSED_W-1:0];
                end
            end
            pdtc_pkg::REQ_LOAD_TIME: n_time = r_load;
            pdtc_pkg::REQ_LOAD_DATE: n_date = r_load;
            default: ;
        endcase
    end

    // State doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= 1'b0;
            r_elapsed   <= '0;
            r_time      <= pdtc_pkg::TIME_RESET;
            r_date      <= pdtc_pkg::DATE_RESET;
            r_uptime    <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step      <= n_step;
                r_elapsed   <= n_elapsed;
                r_time      <= n_time;
                r_date      <= n_date;
                r_uptime    <= n_uptime;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_time_word   = r_time;
    assign o_date_word   = r_date;
    assign o_uptime_ms   = r_uptime;
    assign o_second_step = r_step;

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_time) && $stable(r_date) && $stable(r_uptime))
        else $error("clock state changed without a beat moving through");

    a_load_keeps_uptime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_req != pdtc_pkg::REQ_TICK |=> $stable(r_uptime) && !r_step)
        else $error("non-tick beat touched uptime or stepped the clock");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("processed beat produced no result");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while the pipeline can move");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0]                      REQ_UNUSED      = 2'd3;
    localparam logic [pdtc_pkg::APB_ADDR_W-1:0] PERIOD_ADDR     = pdtc_pkg::ADDR_PERIOD;
    localparam logic [pdtc_pkg::WORD_W-1:0]     EVE_OF_MIDNIGHT = 16'hBF7D;  // 23:59:58
    localparam logic [pdtc_pkg::ELAPSED_W:0]    TWO_SEC_MS      = 12'd2000;

    typedef struct {
        logic [pdtc_pkg::WORD_W-1:0]   time_w;
        logic [pdtc_pkg::WORD_W-1:0]   date_w;
        logic [pdtc_pkg::UPTIME_W-1:0] uptime;
        logic                          step;
    } t_clock_view;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [1:0]                      i_req_type;
    logic [pdtc_pkg::WORD_W-1:0]     i_load_value;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [pdtc_pkg::WORD_W-1:0]     o_time_word;
    logic [pdtc_pkg::WORD_W-1:0]     o_date_word;
    logic [pdtc_pkg::UPTIME_W-1:0]   o_uptime_ms;
    logic                            o_second_step;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pdtc_pkg::APB_ADDR_W-1:0] paddr;
    logic [pdtc_pkg::APB_DATA_W-1:0] pwdata;
    logic [pdtc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Clock state as the block should hold it
    logic [pdtc_pkg::PERIOD_W-1:0]  cfg_period;
    logic [pdtc_pkg::ELAPSED_W-1:0] acc_ms;
    logic [pdtc_pkg::WORD_W-1:0]    wall_time;
    logic [pdtc_pkg::WORD_W-1:0]    wall_date;
    logic [pdtc_pkg::UPTIME_W-1:0]  up_ms;

    logic [4:0] month_len [0:15] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
                                     5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};

    t_clock_view expected_views[$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    packed_date_time_clock_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_load_value  (i_load_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_time_word   (o_time_word),
        .o_date_word   (o_date_word),
        .o_uptime_ms   (o_uptime_ms),
        .o_second_step (o_second_step),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // Day 1 of the next month; past December go to January of the next year
    function automatic logic [pdtc_pkg::WORD_W-1:0] next_month(
        input logic [pdtc_pkg::WORD_W-1:0] d);
        logic [pdtc_pkg::WORD_W-1:0] r;
        r = {d[15:5], 5'd0} + 16'h0021;
        if (r[8:5] > 4'd12) begin
            r = {r[15:9], 9'd0} + 16'h0221;
        end
        return r;
    endfunction

    task automatic predict_clock(input logic [1:0] req,
                                 input logic [pdtc_pkg::WORD_W-1:0] val);
        logic [pdtc_pkg::ELAPSED_W:0] sum;
        t_clock_view                  v;
        v.step = 1'b0;
        case (req)
            pdtc_pkg::REQ_TICK: begin
                up_ms = up_ms + {{(pdtc_pkg::UPTIME_W - pdtc_pkg::PERIOD_W){1'b0}},
                                 cfg_period};
                sum   = {1'b0, acc_ms} + {1'b0, cfg_period};
                if (sum >= TWO_SEC_MS) begin
                    sum    = sum - TWO_SEC_MS;
                    v.step = 1'b1;
                    wall_time = wall_time + 16'd1;
                    if (wall_time[4:0] == 5'd30) begin
                        wall_time = {wall_time[15:5], 5'd0} + 16'h0020;
                        if (wall_time[10:5] == 6'd60) begin
                            wall_time = {wall_time[15:11], 11'd0} + 16'h0800;
                            if (wall_time[15:11] == 5'd24) begin
                                wall_time = '0;
                                if (wall_date[4:0] == 5'd31) begin
                                    wall_date = next_month(wall_date);
                                end else begin
                                    wall_date = wall_date + 16'd1;
                                    if (wall_date[4:0] > 5'd28) begin
                                        // February of a year divisible by four has 29 days
                                        if (wall_date[8:5] == 4'd2 && wall_date[10:9] == 2'd0) begin
                                            if (wall_date[4:0] > 5'd29) begin
                                                wall_date = next_month(wall_date);
                                            end
                                        end else if (wall_date[4:0] > month_len[wall_date[8:5]]) begin
                                            wall_date = next_month(wall_date);
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                acc_ms = sum[pdtc_pkg::ELAPSED_W-1:0];
            end
            pdtc_pkg::REQ_LOAD_TIME: wall_time = val;
            pdtc_pkg::REQ_LOAD_DATE: wall_date = val;
            default: ;
        endcase
        v.time_w = wall_time;
        v.date_w = wall_date;
        v.uptime = up_ms;
        expected_views.push_back(v);
    endtask

    task automatic send_item(input logic [1:0] req, input logic [pdtc_pkg::WORD_W-1:0] val);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_load_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_clock(req, val);
    endtask

    // Drop valid and let every outstanding beat come back
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [pdtc_pkg::PERIOD_W-1:0] ms);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PERIOD_ADDR;
        pwdata  <= pdtc_pkg::APB_DATA_W'(ms);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_period = ms;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[pdtc_pkg::PERIOD_W-1:0] !== ms) begin
            $display("%0t: tick_period_ms readback expected %0d got %0d", $time, ms,
                     prdata[pdtc_pkg::PERIOD_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cross_midnight(input logic [pdtc_pkg::WORD_W-1:0] date);
        send_item(pdtc_pkg::REQ_LOAD_TIME, EVE_OF_MIDNIGHT);
        send_item(pdtc_pkg::REQ_LOAD_DATE, date);
        send_item(pdtc_pkg::REQ_TICK, 16'h0000);
    endtask

    task automatic test_reset_view();
        send_item(REQ_UNUSED, 16'($urandom()));
        send_item(pdtc_pkg::REQ_TICK, 16'hFFFF);
        send_item(REQ_UNUSED, 16'h0000);
        send_item(REQ_UNUSED, 16'hFFFF);
        finish_phase();
    endtask

    task automatic test_calendar_edges();
        write_period(11'd2000);
        cross_midnight(16'hFF9F);  // Dec 31 of the last year, wraps to 1980
        cross_midnight(16'h005D);  // Feb 29 of a leap year
        cross_midnight(16'h025C);  // Feb 28 of a common year
        cross_midnight(16'h009E);  // Apr 30
        cross_midnight(16'h01FF);  // month 15 day 31 carries into the year
        cross_midnight(16'h01BE);  // month 13 is zero days long
        // out-of-range time fields count on by plain binary addition
        send_item(pdtc_pkg::REQ_LOAD_TIME, 16'hFFFF);
        send_item(pdtc_pkg::REQ_TICK, 16'hFFFF);
        send_item(pdtc_pkg::REQ_LOAD_TIME, 16'h07DD);
        send_item(pdtc_pkg::REQ_TICK, 16'h0000);
        finish_phase();
    endtask

    task automatic send_random_item();
        int                          r;
        logic [pdtc_pkg::WORD_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            send_item(pdtc_pkg::REQ_TICK, 16'($urandom()));
        end else if (r < 78) begin
            send_item(pdtc_pkg::REQ_LOAD_TIME, 16'($urandom()));
        end else if (r < 84) begin
            w[15:11] = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 31));
            w[10:5]  = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 63));
            w[4:0]   = $urandom_range(0, 1) ? 5'd29 : 5'($urandom_range(0, 31));
            send_item(pdtc_pkg::REQ_LOAD_TIME, w);
        end else if (r < 90) begin
            send_item(pdtc_pkg::REQ_LOAD_DATE, 16'($urandom()));
        end else if (r < 96) begin
            w[15:9] = 7'($urandom_range(0, 127));
            w[8:5]  = $urandom_range(0, 3) != 0 ? 4'($urandom_range(1, 12))
                                                : 4'($urandom_range(0, 15));
            w[4:0]  = 5'($urandom_range(28, 31));
            send_item(pdtc_pkg::REQ_LOAD_DATE, w);
        end else begin
            send_item(REQ_UNUSED, 16'($urandom()));
        end
    endtask

    task automatic test_random_traffic();
        logic [pdtc_pkg::PERIOD_W-1:0] periods [10];
        periods = '{11'd1, 11'd2047, 11'd0, 11'd1999, 11'd2000,
                    11'($urandom_range(1, 1999)), 11'($urandom_range(1000, 2047)),
                    11'd20, 11'd1000, 11'($urandom_range(0, 2047))};
        foreach (periods[p]) begin
            write_period(periods[p]);
            quiet = (p % 4 == 1);
            repeat (110) send_random_item();
            finish_phase();
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_clock_view want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_views.size() == 0) begin
                $display("%0t: unexpected result beat time %h date %h uptime %h", $time,
                         o_time_word, o_date_word, o_uptime_ms);
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                check_field("time_word", 32'(want.time_w), 32'(o_time_word));
                check_field("date_word", 32'(want.date_w), 32'(o_date_word));
                check_field("uptime_ms", want.uptime, o_uptime_ms);
                check_field("second_step", 32'(want.step), 32'(o_second_step));
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= pdtc_pkg::REQ_TICK;
        i_load_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cfg_period = 11'd20;
        acc_ms     = '0;
        wall_time  = 16'h0000;
        wall_date  = 16'h0021;
        up_ms      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_view();
        test_calendar_edges();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
